[src/scfb_pkg.sv]
// ---------------------------------------------------------------------------
// scfb_pkg: shared definitions for the speech command frame builder
// Frame constants, register indexes and the types that pass between the
// front part, the job queue and the back part.
// ---------------------------------------------------------------------------
package scfb_pkg;

  // Default buffer size in bytes for one frame.
  localparam int FRAME_CAPACITY_DEF = 64;

  // Frame layout.
  localparam logic [7:0] FRAME_START    = 8'hFD;
  localparam logic [7:0] FRAME_ZERO     = 8'h00;
  localparam int         FRAME_OVERHEAD = 7;
  localparam int         HEAD_LEN       = 5;
  localparam logic [7:0] LEN_BIAS       = 8'd4;
  localparam int         BKM_SHIFT      = 3;

  // Header byte positions.
  localparam logic [2:0] HEAD_START = 3'd0;
  localparam logic [2:0] HEAD_ZERO  = 3'd1;
  localparam logic [2:0] HEAD_LEN_B = 3'd2;
  localparam logic [2:0] HEAD_CMD   = 3'd3;
  localparam logic [2:0] HEAD_BKM   = 3'd4;

  // Configuration port.
  localparam int         CFG_IDX_W  = 1;
  localparam int         CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_BKM = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CMD = 1'd1;
  localparam logic [4:0] BKM_RESET = 5'd0;
  localparam logic [7:0] CMD_RESET = 8'd1;

  // Text count field, wide enough for the largest buffer.
  localparam int COUNT_W = 8;

  // One finished message handed from the front part to the back part.
  typedef struct packed {
    logic               drop;
    logic               bank;
    logic [COUNT_W-1:0] count;
    logic [7:0]         cmd;
    logic [4:0]         bkm;
  } job_t;

  // One result item.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       drop;
  } res_t;

endpackage

[src/scfb_ram.sv]
// ---------------------------------------------------------------------------
// scfb_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ---------------------------------------------------------------------------
module scfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/scfb_front.sv]
// ---------------------------------------------------------------------------
// scfb_front: text intake of the frame builder
// Holds the configuration registers, stores text bytes into the current
// buffer bank and hands a job descriptor to the queue on the final byte.
// ---------------------------------------------------------------------------
module scfb_front #(
  parameter int FRAME_CAPACITY = scfb_pkg::FRAME_CAPACITY_DEF,
  localparam int AW = $clog2(FRAME_CAPACITY)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  input  logic [7:0]                       in_text_byte,
  input  logic                             in_is_final,
  output logic                             in_full,
  input  logic                             cfg_we,
  input  logic [scfb_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [scfb_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             ram_we,
  output logic [AW:0]                      ram_waddr,
  output logic [7:0]                       ram_wdata,
  output logic                             job_push,
  output scfb_pkg::job_t                   job,
  input  logic                             job_full
);

  localparam int TEXT_ROOM = FRAME_CAPACITY - scfb_pkg::FRAME_OVERHEAD;

  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          bank_r, bank_nxt;
  logic [4:0]    bkm_r;
  logic [7:0]    cmd_r;
  logic          accept;
  logic          has_room;
  logic [AW-1:0] cnt_inc;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bkm_r <= scfb_pkg::BKM_RESET;
      cmd_r <= scfb_pkg::CMD_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        scfb_pkg::REG_BKM: bkm_r <= cfg_data[4:0];
        scfb_pkg::REG_CMD: cmd_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Both banks busy means the queue is full and intake stalls.
  assign in_full  = job_full;
  assign accept   = in_push & ~job_full;
  assign has_room = (cnt_r < AW'(TEXT_ROOM));
  assign cnt_inc  = cnt_r + AW'(1);

  // Buffer write into the current bank.
  assign ram_we    = accept & has_room;
  assign ram_waddr = {bank_r, cnt_r};
  assign ram_wdata = in_text_byte;

  // Job descriptor for the finished message.
  assign job_push  = accept & in_is_final;
  assign job.drop  = ovf_r | ~has_room;
  assign job.bank  = bank_r;
  assign job.count = scfb_pkg::COUNT_W'(has_room ? cnt_inc : cnt_r);
  assign job.cmd   = cmd_r;
  assign job.bkm   = bkm_r;

  // Count, overflow and bank update per transfer.
  always_comb begin
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    bank_nxt = bank_r;
    if (accept) begin
      if (in_is_final) begin
        cnt_nxt  = '0;
        ovf_nxt  = 1'b0;
        bank_nxt = ~bank_r;
      end else if (has_room) begin
        cnt_nxt = cnt_inc;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      bank_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
      bank_r <= bank_nxt;
    end
  end

endmodule

[src/scfb_jobq.sv]
// ---------------------------------------------------------------------------
// scfb_jobq: two-entry job queue
// Decouples text intake from frame output. An entry stays until its frame
// is fully issued, so the entry count also tracks the buffer banks in use.
// ---------------------------------------------------------------------------
module scfb_jobq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  scfb_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output scfb_pkg::job_t head
);

  scfb_pkg::job_t ent_r [2];
  logic           wp_r, wp_nxt;
  logic           rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_push;
  logic           do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign head    = ent_r[rp_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= push_job;
    end
  end

  // Pointers and fill count.
  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[src/scfb_back.sv]
// ---------------------------------------------------------------------------
// scfb_back: frame output sequencer
// Walks the header, the buffered text, the terminator and the checksum of
// the job at the queue head, or a single drop notice for a dropped job,
// one byte per cycle into a small result queue while that queue has room.
module scfb_back #(
  parameter int FRAME_CAPACITY = scfb_pkg::FRAME_CAPACITY_DEF,
  localparam int AW = $clog2(FRAME_CAPACITY)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_empty,
  input  scfb_pkg::job_t job,
  output logic           job_pop,
  output logic           ram_re,
  output logic [AW:0]    ram_raddr,
  input  logic [7:0]     ram_rdata,
  input  logic           out_pop,
  output logic           out_empty,
  output logic [7:0]     out_frame_byte,
  output logic           out_frame_end,
  output logic           out_dropped
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HEAD = 3'd1;
  localparam logic [2:0] ST_TEXT = 3'd2;
  localparam logic [2:0] ST_TERM = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_DROP = 3'd5;

  localparam int OQ_DEPTH = 4;

  logic [2:0]     st_r, st_nxt;
  logic [2:0]     hidx_r, hidx_nxt;
  logic [AW-1:0]  tidx_r, tidx_nxt;
  logic [AW-1:0]  jcnt;
  logic           issue;
  logic           room;

  // Issue-stage outputs, registered into the data stage.
  logic           b_vld_r, b_vld_nxt;
  logic           b_ram_r, b_ram_nxt;
  logic           b_sum_r, b_sum_nxt;
  logic [7:0]     b_const_r, b_const_nxt;
  logic           b_last_r, b_last_nxt;
  logic           b_drop_r, b_drop_nxt;
  logic [7:0]     chk_r, chk_nxt;
  logic [7:0]     b_data;

  // Result queue.
  scfb_pkg::res_t oq_r [OQ_DEPTH];
  logic [1:0]     owp_r, orp_r;
  logic [2:0]     ocnt_r, ocnt_nxt;
  logic           oq_pop;
  scfb_pkg::res_t oq_in;

  assign jcnt  = job.count[AW-1:0];
  assign room  = ((ocnt_r + 3'(b_vld_r)) < 3'(OQ_DEPTH));
  assign issue = (st_r != ST_IDLE) & room;

  // Sequencer: picks the source of the next frame byte.
  always_comb begin
    st_nxt      = st_r;
    hidx_nxt    = hidx_r;
    tidx_nxt    = tidx_r;
    b_vld_nxt   = issue;
    b_ram_nxt   = 1'b0;
    b_sum_nxt   = 1'b0;
    b_const_nxt = scfb_pkg::FRAME_ZERO;
    b_last_nxt  = 1'b0;
    b_drop_nxt  = 1'b0;
    job_pop     = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = {job.bank, tidx_r};
    case (st_r)
      ST_IDLE: begin
        hidx_nxt = scfb_pkg::HEAD_START;
        tidx_nxt = '0;
        if (!job_empty) begin
          st_nxt = job.drop ? ST_DROP : ST_HEAD;
        end
      end
      ST_HEAD: begin
        case (hidx_r)
          scfb_pkg::HEAD_START: b_const_nxt = scfb_pkg::FRAME_START;
          scfb_pkg::HEAD_LEN_B: b_const_nxt = job.count + scfb_pkg::LEN_BIAS;
          scfb_pkg::HEAD_CMD:   b_const_nxt = job.cmd;
          scfb_pkg::HEAD_BKM:   b_const_nxt = {job.bkm, 3'b000};
          default:              b_const_nxt = scfb_pkg::FRAME_ZERO;
        endcase
        if (issue) begin
          hidx_nxt = hidx_r + 3'd1;
          if (hidx_r == scfb_pkg::HEAD_BKM) begin
            st_nxt = (jcnt == '0) ? ST_TERM : ST_TEXT;
          end
        end
      end
      ST_TEXT: begin
        b_ram_nxt = 1'b1;
        ram_re    = issue;
        if (issue) begin
          tidx_nxt = tidx_r + AW'(1);
          if ((tidx_r + AW'(1)) == jcnt) begin
            st_nxt = ST_TERM;
          end
        end
      end
      ST_TERM: begin
        if (issue) begin
          st_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        b_sum_nxt  = 1'b1;
        b_last_nxt = 1'b1;
        if (issue) begin
          st_nxt  = ST_IDLE;
          job_pop = 1'b1;
        end
      end
      ST_DROP: begin
        b_last_nxt = 1'b1;
        b_drop_nxt = 1'b1;
        if (issue) begin
          st_nxt  = ST_IDLE;
          job_pop = 1'b1;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Data stage: merge buffer data and fold the running checksum.
  assign b_data = b_sum_r ? chk_r : (b_ram_r ? ram_rdata : b_const_r);

  always_comb begin
    chk_nxt = chk_r;
    if (b_vld_r) begin
      chk_nxt = (b_last_r) ? 8'h00 : (chk_r ^ b_data);
    end
  end

  assign oq_in.data = b_data;
  assign oq_in.last = b_last_r;
  assign oq_in.drop = b_drop_r;

  always_ff @(posedge clk) begin
    b_ram_r   <= b_ram_nxt;
    b_sum_r   <= b_sum_nxt;
    b_const_r <= b_const_nxt;
    b_last_r  <= b_last_nxt;
    b_drop_r  <= b_drop_nxt;
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      hidx_r  <= scfb_pkg::HEAD_START;
      tidx_r  <= '0;
      b_vld_r <= 1'b0;
      chk_r   <= 8'h00;
    end else begin
      st_r    <= st_nxt;
      hidx_r  <= hidx_nxt;
      tidx_r  <= tidx_nxt;
      b_vld_r <= b_vld_nxt;
      chk_r   <= chk_nxt;
    end
  end

  // Result queue; issue is held back so it never overflows.
  assign out_empty      = (ocnt_r == 3'd0);
  assign oq_pop         = out_pop & ~out_empty;
  assign out_frame_byte = oq_r[orp_r].data;
  assign out_frame_end  = oq_r[orp_r].last;
  assign out_dropped    = oq_r[orp_r].drop;
  assign ocnt_nxt       = ocnt_r + 3'(b_vld_r) - 3'(oq_pop);

  always_ff @(posedge clk) begin
    if (b_vld_r) begin
      oq_r[owp_r] <= oq_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 2'd0;
      orp_r  <= 2'd0;
      ocnt_r <= 3'd0;
    end else begin
      owp_r  <= owp_r + 2'(b_vld_r);
      orp_r  <= orp_r + 2'(oq_pop);
      ocnt_r <= ocnt_nxt;
    end
  end

endmodule

[src/speech_command_frame_builder.sv]
// ---------------------------------------------------------------------------
// speech_command_frame_builder: XOR-checksummed speech command framer
// Buffers the text of one message and sends it framed with a header, a
// terminator and an XOR checksum, or a single drop notice if too long.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  in_       input      in_push / in_full   in_text_byte, in_is_final
//  out_      output     out_pop / out_empty out_frame_byte, out_frame_end,
//                                           out_dropped
//  cfg_      input      cfg_we              cfg_idx, cfg_data
//
//  Text bytes are taken one per cycle and written into one of two buffer
//  banks. A frame of N text bytes is N + 7 bytes long and leaves at one
//  byte per cycle. Intake stalls only while both banks hold messages not
//  yet fully issued; output stalls are absorbed by a four-entry result queue.
//  Reset is synchronous and active low; no clearing pass is needed.
// ---------------------------------------------------------------------------
module speech_command_frame_builder #(
  parameter int FRAME_CAPACITY = scfb_pkg::FRAME_CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [7:0]                      in_text_byte,
  input  logic                            in_is_final,
  input  logic                            out_pop,
  output logic                            out_empty,
  output logic [7:0]                      out_frame_byte,
  output logic                            out_frame_end,
  output logic                            out_dropped,
  input  logic                            cfg_we,
  input  logic [scfb_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [scfb_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(FRAME_CAPACITY);

  logic           ram_we;
  logic [AW:0]    ram_waddr;
  logic [7:0]     ram_wdata;
  logic           ram_re;
  logic [AW:0]    ram_raddr;
  logic [7:0]     ram_rdata;
  logic           job_push;
  logic           job_full;
  logic           job_pop;
  logic           job_empty;
  scfb_pkg::job_t job_in;
  scfb_pkg::job_t job_head;

  // Text intake and configuration.
  scfb_front #(.FRAME_CAPACITY(FRAME_CAPACITY)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_text_byte (in_text_byte),
    .in_is_final  (in_is_final),
    .in_full      (in_full),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .job_push     (job_push),
    .job          (job_in),
    .job_full     (job_full)
  );

  // Two-bank text buffer.
  scfb_ram #(.WIDTH(8), .DEPTH(2 ** (AW + 1))) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Job queue between intake and output.
  scfb_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job_in),
    .full     (job_full),
    .pop      (job_pop),
    .empty    (job_empty),
    .head     (job_head)
  );

  // Frame output.
  scfb_back #(.FRAME_CAPACITY(FRAME_CAPACITY)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_empty      (job_empty),
    .job            (job_head),
    .job_pop        (job_pop),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_frame_byte (out_frame_byte),
    .out_frame_end  (out_frame_end),
    .out_dropped    (out_dropped)
  );

endmodule

[dv/scfb_frame_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scfb_frame_checker: result predictor and scoreboard for the frame builder
// Watches the text, result and register channels. Every accepted text byte
// goes through a model of the message buffer, and a final byte turns into
// the expected frame or drop notice. Every accepted result byte is compared,
// field by field, with the oldest expected one.
// ---------------------------------------------------------------------------
module scfb_frame_checker
  import scfb_pkg::*;
#(
  parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  logic                  in_full,
  input  logic [7:0]            in_text_byte,
  input  logic                  in_is_final,
  input  logic                  out_pop,
  input  logic                  out_empty,
  input  logic [7:0]            out_frame_byte,
  input  logic                  out_frame_end,
  input  logic                  out_dropped,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    waiting,
  output int                    frames_built,
  output int                    frames_dropped,
  output int                    bytes_checked
);

  // Longest text whose frame still fits in the buffer.
  localparam int TEXT_ROOM    = FRAME_CAPACITY - FRAME_OVERHEAD;
  localparam int REPORT_LIMIT = 10;

  // Model of the message buffer and the two registers.
  logic [7:0] text_buf [FRAME_CAPACITY];
  int         text_len;
  bit         too_long;
  logic [4:0] music_no;
  logic [7:0] command;

  // Expected result bytes, oldest first.
  res_t       frame_queue [$];
  res_t       want;
  logic [7:0] xor_sum;

  int n_bad;
  int n_built;
  int n_dropped;
  int n_checked;

  // Queues one ordinary frame byte and folds it into the running checksum.
  task automatic queue_frame_byte(input logic [7:0] b, inout logic [7:0] sum);
    res_t r;
    r.data = b;
    r.last = 1'b0;
    r.drop = 1'b0;
    frame_queue.push_back(r);
    sum = sum ^ b;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      text_len = 0;
      too_long = 1'b0;
      music_no = BKM_RESET;
      command  = CMD_RESET;
      frame_queue.delete();
    end else begin
      // Register writes take effect for messages that end after them.
      if (cfg_we) begin
        case (cfg_idx)
          REG_BKM: music_no = cfg_data[4:0];
          REG_CMD: command  = cfg_data[7:0];
          default: ;
        endcase
      end

      // Compare an accepted result with the oldest expectation.
      if (out_pop && !out_empty) begin
        if (frame_queue.size() == 0) begin
          n_bad++;
          if (n_bad <= REPORT_LIMIT)
            $display("[%0t] unexpected result: byte %02h end %0b drop %0b", $time,
                     out_frame_byte, out_frame_end, out_dropped);
        end else begin
          want = frame_queue.pop_front();
          n_checked++;
          if (out_frame_byte !== want.data || out_frame_end !== want.last ||
              out_dropped !== want.drop) begin
            n_bad++;
            if (n_bad <= REPORT_LIMIT)
              $display("[%0t] result %0d: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                       $time, n_checked, want.data, want.last, want.drop,
                       out_frame_byte, out_frame_end, out_dropped);
          end
        end
      end

      // Store the text byte if there is room; a final byte closes the message.
      if (in_push && !in_full) begin
        if (text_len < TEXT_ROOM) begin
          text_buf[text_len] = in_text_byte;
          text_len++;
        end else begin
          too_long = 1'b1;
        end

        if (in_is_final) begin
          if (too_long) begin
            want.data = 8'h00;
            want.last = 1'b1;
            want.drop = 1'b1;
            frame_queue.push_back(want);
            n_dropped++;
          end else begin
            xor_sum = 8'h00;
            queue_frame_byte(FRAME_START, xor_sum);
            queue_frame_byte(FRAME_ZERO, xor_sum);
            queue_frame_byte(8'(text_len) + LEN_BIAS, xor_sum);
            queue_frame_byte(command, xor_sum);
            queue_frame_byte(8'(music_no) << BKM_SHIFT, xor_sum);
            for (int i = 0; i < text_len; i++)
              queue_frame_byte(text_buf[i], xor_sum);
            queue_frame_byte(FRAME_ZERO, xor_sum);
            want.data = xor_sum;
            want.last = 1'b1;
            want.drop = 1'b0;
            frame_queue.push_back(want);
            n_built++;
          end
          text_len = 0;
          too_long = 1'b0;
        end
      end
    end

    // Counts seen by the testbench top change only after this edge.
    mismatches     <= n_bad;
    waiting        <= frame_queue.size();
    frames_built   <= n_built;
    frames_dropped <= n_dropped;
    bytes_checked  <= n_checked;
  end

endmodule

[dv/speech_command_frame_builder_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// speech_command_frame_builder_tb: stimulus and verdict for the frame builder
// Sends directed messages at the register extremes, then random messages of
// mostly short and a few maximal and overlong lengths under random register
// settings, with random gaps on both channels and one long output hold-off.
// The frame checker predicts and compares every result transfer.
// ---------------------------------------------------------------------------
module speech_command_frame_builder_tb;
  import scfb_pkg::*;

  localparam int CAPACITY      = FRAME_CAPACITY_DEF;
  localparam int TEXT_ROOM     = CAPACITY - FRAME_OVERHEAD;
  localparam int ITEM_TARGET   = 250;
  localparam int CALM_AFTER    = 200;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_PHASE    = 2;
  localparam int SETTLE_CYCLES = 20;
  localparam int DRAIN_CYCLES  = 40;
  localparam int STALL_LIMIT   = 5000;

  typedef logic [7:0] text_q_t [$];

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  in_push      = 1'b0;
  logic                  in_full;
  logic [7:0]            in_text_byte = 8'h00;
  logic                  in_is_final  = 1'b0;
  logic                  out_pop      = 1'b0;
  logic                  out_empty;
  logic [7:0]            out_frame_byte;
  logic                  out_frame_end;
  logic                  out_dropped;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx      = REG_BKM;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  int mismatches;
  int waiting;
  int frames_built;
  int frames_dropped;
  int bytes_checked;

  // Flags shared between the sender and the result taker, and the sender's counts.
  bit idle_on        = 1'b1;
  bit hold_req       = 1'b0;
  int items_sent     = 0;
  int settings_used  = 0;

  always #5 clk = ~clk;

  speech_command_frame_builder #(
    .FRAME_CAPACITY(CAPACITY)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_text_byte  (in_text_byte),
    .in_is_final   (in_is_final),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_frame_byte(out_frame_byte),
    .out_frame_end (out_frame_end),
    .out_dropped   (out_dropped),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_data      (cfg_data)
  );

  scfb_frame_checker #(
    .FRAME_CAPACITY(CAPACITY)
  ) u_frame_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_text_byte  (in_text_byte),
    .in_is_final   (in_is_final),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_frame_byte(out_frame_byte),
    .out_frame_end (out_frame_end),
    .out_dropped   (out_dropped),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .waiting       (waiting),
    .frames_built  (frames_built),
    .frames_dropped(frames_dropped),
    .bytes_checked (bytes_checked)
  );

  // Offers one text byte, after an optional random gap, until it transfers.
  task automatic send_text(input logic [7:0] b, input logic fin);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push      <= 1'b1;
    in_text_byte <= b;
    in_is_final  <= fin;
    @(posedge clk);
    while (in_full) @(posedge clk);
    items_sent++;
  endtask

  // Sends a whole message; the last byte carries the final mark.
  task automatic send_message(input text_q_t text);
    foreach (text[i]) send_text(text[i], i == text.size() - 1);
  endtask

  // Stops sending and waits until every expected result has been taken.
  task automatic quiesce();
    in_push <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers while the block is idle. The unused upper data
  // bits of the music number are filled with noise.
  task automatic configure(input logic [4:0] music, input logic [7:0] cmd);
    quiesce();
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_BKM;
    cfg_data <= {3'($urandom_range(0, 7)), music};
    @(posedge clk);
    cfg_idx  <= REG_CMD;
    cfg_data <= cmd;
    @(posedge clk);
    cfg_we   <= 1'b0;
    settings_used++;
  endtask

  // Result side: random pop gaps, plus one long hold-off on request.
  initial begin : result_taker
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 14);
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Ends the run if no transfer happens on either channel for too long.
  initial begin : stall_watch
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty))
        quiet = 0;
      else
        quiet++;
    end
    $display("[%0t] no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Main stimulus.
  initial begin : stimulus
    text_q_t    msg;
    logic [4:0] music;
    logic [7:0] cmd;
    int         len;
    int         pick;
    int         msg_no;
    int         phase_no;
    int         n_msgs;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset register values with a single zero text byte.
    msg = {8'h00};
    send_message(msg);

    // Directed: register extremes, one-byte and all-zero messages.
    configure(5'd31, 8'h00);
    msg = {8'hFF};
    send_message(msg);
    configure(5'd0, 8'hFF);
    msg = {8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE};
    send_message(msg);
    configure(5'd31, 8'hFF);
    msg = {8'h55, 8'hAA};
    send_message(msg);
    msg = {8'h00, 8'h00, 8'h00};
    send_message(msg);
    msg = {8'h5A};
    send_message(msg);

    // Random messages, mostly short; one exactly fits the buffer and one
    // is a single byte too long.
    msg_no   = 0;
    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) begin
        music = $urandom_range(0, 1) ? 5'd31 : 5'd0;
        cmd   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else begin
        music = 5'($urandom_range(0, 31));
        cmd   = 8'($urandom_range(0, 255));
      end
      configure(music, cmd);

      n_msgs = (phase_no == HOLD_PHASE) ? 5 : $urandom_range(1, 4);
      for (int m = 0; m < n_msgs; m++) begin
        // The receiver holds off while several messages pile up.
        if (phase_no == HOLD_PHASE && m == 0) hold_req = 1'b1;

        pick = $urandom_range(0, 99);
        if (msg_no == 1)
          len = TEXT_ROOM;
        else if (msg_no == 4)
          len = TEXT_ROOM + 1;
        else if (pick < 80)
          len = $urandom_range(1, 8);
        else if (pick < 95)
          len = $urandom_range(9, 30);
        else
          len = $urandom_range(TEXT_ROOM - 2, TEXT_ROOM + 4);

        msg.delete();
        repeat (len) msg.push_back(8'($urandom_range(0, 255)));
        send_message(msg);
        msg_no++;
        if (items_sent >= CALM_AFTER) idle_on = 1'b0;
      end
      phase_no++;
    end

    // Drain and give the verdict.
    idle_on = 1'b0;
    in_push <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d text bytes under %0d register settings.", items_sent,
             settings_used + 1);
    $display("Checked %0d result bytes: %0d frames built, %0d drop notices.",
             bytes_checked, frames_built, frames_dropped);
    if (mismatches == 0 && waiting == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
